FILE: hw/rtl/gcr_pkg.sv
// gcr_pkg: beat types and fixed constants shared by the grid ray caster
// no dependencies; imported by every module of the block
package gcr_pkg;

  // input beat: tile write or ray cast
  typedef struct packed {
    logic        func;
    logic [4:0]  tile_x;
    logic [4:0]  tile_y;
    logic [3:0]  tile_type;
    logic [15:0] player_x;
    logic [15:0] player_y;
    logic [11:0] ray_angle;
    logic [11:0] view_angle;
  } in_item_t;

  // output beat: one per cast
  typedef struct packed {
    logic [15:0] distance;
    logic [3:0]  wall_type;
    logic        hit_side;
    logic        out_of_range;
  } out_item_t;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  // sine polynomial, Q1.14
  localparam int TRIG_SH   = 14;
  localparam int TRIG_ONE  = 16384;
  localparam int POLY_A    = 1160;
  localparam int POLY_B    = 10512;
  localparam int POLY_C    = 25736;

  localparam logic [15:0] MAX_DIST_RST = 16'd46341;
  localparam logic [16:0] DIST_SAT     = 17'h10000;
  localparam int          CUW          = 12;

endpackage

FILE: hw/rtl/gcr_div.sv
// gcr_div: restoring divider, one quotient bit per cycle
// uses gcr_pkg; instantiated by grid_ray_caster_core
module gcr_div
  import gcr_pkg::*;
#(
  parameter int NW = 25,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] dvs;
  logic [DW-1:0] rem;
  logic [NW-1:0] quo;
  logic [CW-1:0] cnt;
  logic [DW:0]   shifted;
  logic [DW+1:0] trial;

  // one trial subtraction
  always_comb begin
    shifted = {rem, quo[NW-1]};
    trial   = (DW+2)'(shifted) - (DW+2)'(dvs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (!trial[DW+1]) begin
        rem <= trial[DW-1:0];
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= shifted[DW-1:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

FILE: hw/rtl/gcr_tile_mem.sv
// gcr_tile_mem: tile map store, one write and one registered read port
// uses gcr_pkg; instantiated by grid_ray_caster_core
module gcr_tile_mem
  import gcr_pkg::*;
#(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [3:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [3:0]    rdata
);

  logic [3:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/grid_ray_caster_core.sv
// grid_ray_caster_core: tile map ray caster, trig sequencer, grid walker
// uses gcr_pkg, gcr_div, gcr_tile_mem
//
//  channel | signals                     | beat
//  --------+-----------------------------+-------------------------------
//  cfg     | cfg_wr_en, cfg_wr_data      | max_distance write, no stall
//  in      | in_valid, in_ready, in_data | tile write or ray cast
//  out     | out_valid, out_ready, out_data | one result per cast
//
// a tile write is taken while idle; a cast runs the sine, cosine and
// corrected-angle trig passes, then two walks with their first-crossing and step divisions
// and a check, address and read step per crossing, paced by the shared bit-serial divider.
// rst is synchronous; the tile map is not cleared and must be written first.
// in_ready is high only while idle; a finished result waits in the output
// register and holds the sequencer only if the previous one is still there.
module grid_ray_caster_core
  import gcr_pkg::*;
#(
  parameter int MAP_W      = 32,
  parameter int MAP_H      = 32,
  parameter int POS_FRAC   = 10,
  parameter int ANGLE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  localparam int AB      = ANGLE_BITS;
  localparam int PF      = POS_FRAC;
  localparam int XB      = $clog2(MAP_W);
  localparam int YB      = $clog2(MAP_H);
  localparam int AW      = XB + YB;
  localparam int NW      = PF + 15;
  localparam int QUARTER = 1 << (AB - 2);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_TLOAD  = 16'h0002,
    S_T0     = 16'h0004,
    S_T1     = 16'h0008,
    S_T2     = 16'h0010,
    S_T3     = 16'h0020,
    S_T4     = 16'h0040,
    S_WSETUP = 16'h0080,
    S_DIVD   = 16'h0100,
    S_DIVDD  = 16'h0200,
    S_CHK    = 16'h0400,
    S_ADDR   = 16'h0800,
    S_READ   = 16'h1000,
    S_WEND   = 16'h2000,
    S_PICK   = 16'h4000,
    S_FIN    = 16'h8000
  } state_t;

  state_t state;

  logic [15:0]    max_dist;
  logic [15:0]    px, py;
  logic [AB-1:0]  ra, va;
  logic [1:0]     trig_sel;
  logic [15:0]    t_val, t2;
  logic           t_neg;
  logic [15:0]    s_mag, c_mag, cd_mag;
  logic           s_neg, c_neg, cd_neg;
  logic           axis;
  logic [16:0]    d, dd;
  logic signed [CUW-1:0] cu;
  logic           cur_hit;
  logic [15:0]    cur_dist;
  logic [3:0]     cur_type;
  logic           wv_hit;
  logic [15:0]    wv_dist;
  logic [3:0]     wv_type;
  logic           best_miss, best_side;
  logic [3:0]     best_type;
  logic [31:0]    prod;
  logic [15:0]    ma, mb;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_dist <= MAX_DIST_RST;
    end else if (cfg_wr_en) begin
      max_dist <= cfg_wr_data;
    end
  end

  assign in_ready = (state == S_IDLE);
  logic in_fire;
  assign in_fire = in_valid && in_ready;

  // tile writes go straight to the map
  logic [6:0] tx_ext, ty_ext;
  logic       map_we;
  logic [AW-1:0] waddr, raddr;
  logic [3:0] rd_data;
  assign tx_ext = 7'(in_data.tile_x);
  assign ty_ext = 7'(in_data.tile_y);
  assign map_we = in_fire && (in_data.func == FUNC_WRITE)
                  && (tx_ext < 7'(MAP_W)) && (ty_ext < 7'(MAP_H));
  assign waddr  = {ty_ext[YB-1:0], tx_ext[XB-1:0]};

  // angle fold for the sine sequencer
  logic [AB-1:0] ang;
  logic [AB-2:0] fold_x;
  logic [15:0]   fold_t;
  always_comb begin
    case (trig_sel)
      2'd0:    ang = ra;
      2'd1:    ang = ra + AB'(QUARTER);
      default: ang = ra - va + AB'(QUARTER);
    endcase
    fold_x = ang[AB-2] ? ((AB-1)'(QUARTER) - (AB-1)'(ang[AB-3:0]))
                       : (AB-1)'(ang[AB-3:0]);
    fold_t = 16'(fold_x) << (16 - AB);
  end

  // per-axis walk view
  logic [15:0] pu, pw, du_mag, dw_mag;
  logic        du_neg, dw_neg;
  logic [PF-1:0] pu_frac;
  logic [PF-1:0] off;
  logic signed [CUW-1:0] cu_init;
  always_comb begin
    pu     = axis ? py : px;
    pw     = axis ? px : py;
    du_mag = axis ? s_mag : c_mag;
    du_neg = axis ? s_neg : c_neg;
    dw_mag = axis ? c_mag : s_mag;
    dw_neg = axis ? c_neg : s_neg;
    pu_frac = pu[PF-1:0];
    if (!du_neg) begin
      off     = (pu_frac == '0) ? '0 : PF'((1 << PF) - 1) - pu_frac + 1'b1;
      cu_init = CUW'(pu[15:PF]) + CUW'(pu_frac != '0);
    end else begin
      off     = pu_frac;
      cu_init = CUW'(pu[15:PF]) - CUW'(1);
    end
  end

  // divider shared by both walks
  logic          div_start, div_busy, div_done;
  logic [NW-1:0] div_n, div_q;
  logic [16:0]   q_sat;
  assign div_start = ((state == S_WSETUP) && (du_mag != '0))
                     || ((state == S_DIVD) && div_done);
  assign div_n = (state == S_WSETUP) ? (NW'(off) << TRIG_SH) : (NW'(1) << (PF + TRIG_SH));
  assign q_sat = (div_q > NW'(16'hFFFF)) ? DIST_SAT : div_q[16:0];

  gcr_div #(.NW(NW), .DW(16)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (du_mag),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // crossing point and bounds
  logic [16:0]        ow;
  logic signed [18:0] pwa, cw;
  logic               cross_miss;
  logic [XB-1:0]      cx;
  logic [YB-1:0]      cy;
  always_comb begin
    ow  = prod[30:14];
    pwa = dw_neg ? (19'(pw) - 19'(ow)) : (19'(pw) + 19'(ow));
    cw  = pwa >>> PF;
    cross_miss = pwa[18] || cu[CUW-1]
                 || (cu >= $signed(CUW'(axis ? MAP_H : MAP_W)))
                 || (cw >= $signed(19'(axis ? MAP_W : MAP_H)));
    cx = axis ? cw[XB-1:0] : cu[XB-1:0];
    cy = axis ? cu[YB-1:0] : cw[YB-1:0];
  end
  assign raddr = {cy, cx};

  gcr_tile_mem #(.AW(AW)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (waddr),
    .wdata (in_data.tile_type),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // nearer hit
  logic        v_wins;
  logic [15:0] best_dist;
  assign v_wins    = wv_hit && (!cur_hit || (wv_dist < cur_dist));
  assign best_dist = v_wins ? wv_dist : cur_dist;

  // shared multiplier, operands picked by state
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_T0: begin
        ma = t_val;
        mb = t_val;
      end
      S_T1: begin
        ma = 16'(POLY_A);
        mb = prod[29:14];
      end
      S_T2: begin
        ma = 16'(POLY_B) - prod[29:14];
        mb = t2;
      end
      S_T3: begin
        ma = 16'(POLY_C) - prod[29:14];
        mb = t_val;
      end
      S_CHK: begin
        ma = d[15:0];
        mb = dw_mag;
      end
      // corrected distance held while the result waits
      S_PICK, S_FIN: begin
        ma = best_dist;
        mb = cd_mag;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 32'(ma) * 32'(mb);
  end

  logic [15:0] sin_val;
  logic [17:0] dsum;
  assign sin_val = (prod[31:14] > 18'(TRIG_ONE)) ? 16'(TRIG_ONE) : prod[29:14];
  assign dsum    = 18'(d) + 18'(dd);

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire && (in_data.func == FUNC_CAST)) begin
            state <= S_TLOAD;
          end
        end
        S_TLOAD: state <= S_T0;
        S_T0:    state <= S_T1;
        S_T1:    state <= S_T2;
        S_T2:    state <= S_T3;
        S_T3:    state <= S_T4;
        S_T4: begin
          state <= (trig_sel == 2'd2) ? S_WSETUP : S_TLOAD;
        end
        S_WSETUP: begin
          state <= (du_mag == '0) ? S_WEND : S_DIVD;
        end
        S_DIVD: begin
          if (div_done) begin
            state <= S_DIVDD;
          end
        end
        S_DIVDD: begin
          if (div_done) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          state <= (d > {1'b0, max_dist}) ? S_WEND : S_ADDR;
        end
        S_ADDR: begin
          state <= cross_miss ? S_WEND : S_READ;
        end
        S_READ: begin
          state <= (rd_data != '0) ? S_WEND : S_CHK;
        end
        S_WEND: begin
          state <= axis ? S_PICK : S_WSETUP;
        end
        S_PICK: state <= S_FIN;
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        px       <= in_data.player_x;
        py       <= in_data.player_y;
        ra       <= AB'(16'(in_data.ray_angle));
        va       <= AB'(16'(in_data.view_angle));
        trig_sel <= 2'd0;
        axis     <= 1'b0;
      end
      S_TLOAD: begin
        t_val <= fold_t;
        t_neg <= ang[AB-1];
      end
      S_T1: t2 <= prod[29:14];
      S_T4: begin
        case (trig_sel)
          2'd0: begin
            s_mag <= sin_val;
            s_neg <= t_neg;
          end
          2'd1: begin
            c_mag <= sin_val;
            c_neg <= t_neg;
          end
          default: begin
            cd_mag <= sin_val;
            cd_neg <= t_neg;
          end
        endcase
        trig_sel <= trig_sel + 2'd1;
      end
      S_WSETUP: begin
        cur_hit <= 1'b0;
        cu      <= cu_init;
      end
      S_DIVD: begin
        if (div_done) begin
          d <= q_sat;
        end
      end
      S_DIVDD: begin
        if (div_done) begin
          dd <= q_sat;
        end
      end
      S_READ: begin
        if (rd_data != '0) begin
          cur_hit  <= 1'b1;
          cur_dist <= d[15:0];
          cur_type <= rd_data;
        end else begin
          d  <= dsum[17:16] != 2'b00 ? DIST_SAT : dsum[16:0];
          cu <= du_neg ? (cu - CUW'(1)) : (cu + CUW'(1));
        end
      end
      S_WEND: begin
        if (!axis) begin
          wv_hit  <= cur_hit;
          wv_dist <= cur_dist;
          wv_type <= cur_type;
          axis    <= 1'b1;
        end
      end
      S_PICK: begin
        best_miss <= !(wv_hit || cur_hit);
        best_side <= !v_wins;
        best_type <= v_wins ? wv_type : cur_type;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          if (best_miss) begin
            out_data.distance     <= 16'hFFFF;
            out_data.wall_type    <= '0;
            out_data.hit_side     <= 1'b0;
            out_data.out_of_range <= 1'b1;
          end else begin
            out_data.distance     <= (cd_neg || cd_mag == '0) ? '0 : prod[29:14];
            out_data.wall_type    <= best_type;
            out_data.hit_side     <= best_side;
            out_data.out_of_range <= 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_read_after_addr: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> $past(state == S_ADDR))
    else $error("tile read without address cycle");

  a_hit_in_limit: assert property (@(posedge clk) disable iff (rst)
    ((state == S_READ) && (rd_data != '0)) |-> (d <= {1'b0, max_dist}))
    else $error("hit recorded beyond distance limit");

  a_hit_type: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.out_of_range) |-> (out_data.wall_type != '0))
    else $error("hit result with empty wall type");

  a_miss_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.out_of_range)
      |-> (out_data.distance == 16'hFFFF && out_data.wall_type == '0))
    else $error("miss result not saturated");

endmodule
